// ===== hw/rtl/gaussian_row_smoother_core_assert.svh =====
// Assertion macros shared by the row smoother RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef GAUSSIAN_ROW_SMOOTHER_CORE_ASSERT_SVH
`define GAUSSIAN_ROW_SMOOTHER_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define GSR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define GSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/gsr_pkg.sv =====
// Package for the Gaussian row smoother: sizes, word types, states and the exp table.
// Used by every module of the block except gsr_ram; depends on nothing.
package gsr_pkg;

	localparam int HALF_WIDTH      = 32;
	localparam int WIN_LEN         = 2 * HALF_WIDTH + 1;
	localparam int EXP_TABLE_DEPTH = 1024;
	localparam int MAX_ROW         = 4096;

	localparam int POS_W   = $clog2(MAX_ROW);
	localparam int SLOT_W  = $clog2(WIN_LEN);
	localparam int DIST_W  = $clog2(HALF_WIDTH + 1);
	localparam int INV_W   = 20;
	localparam int EXP_W   = 31;
	localparam int ROM_AW  = $clog2(EXP_TABLE_DEPTH);
	localparam int ZQ_W    = DIST_W + INV_W;
	localparam int ZSQ_W   = 2 * ZQ_W;
	localparam int IDX_SHIFT = 34 - ROM_AW;
	localparam int IDXQ_W  = $clog2(5 * EXP_TABLE_DEPTH);
	localparam int RECIP_W = 14;
	localparam int EXP_Y_SHIFT = 26 - ROM_AW;

	localparam logic [INV_W-1:0]   INV_RESET   = INV_W'(65536);
	localparam logic [28:0]        INV_SQRT_2PI = 29'd428361012;
	localparam logic [ZSQ_W-1:0]   ZSQ_LIMIT   = ZSQ_W'(64'd20 << 32);
	localparam logic [RECIP_W-1:0] RECIP_5     = RECIP_W'(13108);
	localparam logic [63:0]        Q30_ONE     = 64'd1073741824;
	localparam logic [63:0]        Q30_HALF    = 64'd536870912;

	localparam int APB_AW = 3;
	localparam logic [APB_AW-1:0] REG_INV_SIGMA = 3'h0;

	typedef struct packed {
		logic signed [31:0] sample;
		logic               row_end;
	} item_t;

	typedef struct packed {
		logic [30:0] smoothed;
		logic        row_last;
	} result_t;

	typedef struct packed {
		logic [POS_W-1:0]  j;
		logic [POS_W-1:0]  lo;
		logic [POS_W-1:0]  hi;
		logic [SLOT_W-1:0] lo_slot;
		logic              last;
	} job_t;

	typedef struct packed {
		logic jobs_idle;
		logic job_room;
	} queue_status_t;

	typedef enum logic {
		FR_ACCEPT,
		FR_FLUSH
	} front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_DRAIN
	} back_state_t;

	typedef logic [EXP_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		r = (s == SLOT_W'(WIN_LEN - 1)) ? '0 : s + SLOT_W'(1);
		return r;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] s,
		input logic [SLOT_W-1:0] n);
		logic [SLOT_W-1:0] r;
		r = (s >= n) ? s - n : s + (SLOT_W'(WIN_LEN) - n);
		return r;
	endfunction

	function automatic exp_rom_t build_exp_rom();
		exp_rom_t    rom;
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] v;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			y    = 64'(i * 10) << EXP_Y_SHIFT;
			term = Q30_ONE;
			pos  = Q30_ONE;
			neg  = '0;
			for (int k = 1; k <= 16; k++) begin
				term = ((term * y) >> 30) / 64'(k);
				if (k[0]) begin
					neg = neg + term;
				end else begin
					pos = pos + term;
				end
			end
			v = pos - neg;
			for (int q = 0; q < 4; q++) begin
				v = (v * v + Q30_HALF) >> 30;
			end
			rom[i] = v[EXP_W-1:0];
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ===== hw/rtl/gaussian_row_smoother_core.sv =====
// Top level of the Gaussian row smoother: config register, job and result queues, window RAM.
// Depends on gsr_pkg, gsr_ram, gsr_front, gsr_back and the assertion macro header.
//
// Channel   Handshake          Word
// input     push / full        item   (sample, row_end)
// result    pop / empty        result (smoothed, row_last)
// config    APB psel/penable   inv_sigma at address 0
//
// The back end runs each output channel through its single multiply-accumulate pipeline.
// A sample word is taken only when no job is queued or running, so a word that yields a
// channel is followed by the next one only after the back end has finished that channel.
// The word after the last word of a row waits for the whole flush of up to 33 channels.
// Reset clears all control state; the window needs no clearing.
// A full result queue holds the back end before its next job, never the pipeline.
`include "gaussian_row_smoother_core_assert.svh"

module gaussian_row_smoother_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  gsr_pkg::item_t              item,
	output logic                        empty,
	input  logic                        pop,
	output gsr_pkg::result_t            result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gsr_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic [gsr_pkg::INV_W-1:0]  inv_q;
	gsr_pkg::queue_status_t     qstat;
	gsr_pkg::job_t              job_in, jq_q [2];
	logic                       job_push, job_pop, back_busy;
	logic                       jq_wp_q, jq_rp_q;
	logic [1:0]                 jq_cnt_q;
	gsr_pkg::result_t           res_in, rq_q [2];
	logic                       res_push, rq_wp_q, rq_rp_q;
	logic [1:0]                 rq_cnt_q;
	logic                       win_we;
	logic [gsr_pkg::SLOT_W-1:0] win_waddr, win_raddr;
	logic [31:0]                win_wdata, win_rdata;
	logic                       out_pop;

	assign pready = 1'b1;
	assign prdata = (paddr == gsr_pkg::REG_INV_SIGMA) ? 32'(inv_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= gsr_pkg::INV_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr == gsr_pkg::REG_INV_SIGMA) begin
			inv_q <= pwdata[gsr_pkg::INV_W-1:0];
		end
	end

	assign qstat.jobs_idle = (jq_cnt_q == 2'd0) && !back_busy;
	assign qstat.job_room  = (jq_cnt_q != 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jq_wp_q  <= 1'b0;
			jq_rp_q  <= 1'b0;
			jq_cnt_q <= '0;
			rq_wp_q  <= 1'b0;
			rq_rp_q  <= 1'b0;
			rq_cnt_q <= '0;
		end else begin
			if (job_push) begin
				jq_wp_q <= !jq_wp_q;
			end
			if (job_pop) begin
				jq_rp_q <= !jq_rp_q;
			end
			jq_cnt_q <= jq_cnt_q + 2'(job_push) - 2'(job_pop);
			if (res_push) begin
				rq_wp_q <= !rq_wp_q;
			end
			if (out_pop) begin
				rq_rp_q <= !rq_rp_q;
			end
			rq_cnt_q <= rq_cnt_q + 2'(res_push) - 2'(out_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (job_push) begin
			jq_q[jq_wp_q] <= job_in;
		end
		if (res_push) begin
			rq_q[rq_wp_q] <= res_in;
		end
	end

	assign empty   = (rq_cnt_q == 2'd0);
	assign out_pop = pop && !empty;
	assign result  = rq_q[rq_rp_q];

	gsr_ram #(
		.WIDTH(32),
		.DEPTH(gsr_pkg::WIN_LEN)
	) u_window (
		.clk  (clk),
		.we   (win_we),
		.waddr(win_waddr),
		.wdata(win_wdata),
		.raddr(win_raddr),
		.rdata(win_rdata)
	);

	gsr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.qstat    (qstat),
		.job_push (job_push),
		.job      (job_in),
		.win_we   (win_we),
		.win_waddr(win_waddr),
		.win_wdata(win_wdata)
	);

	gsr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.inv_sigma(inv_q),
		.job_valid(jq_cnt_q != 2'd0),
		.job      (jq_q[jq_rp_q]),
		.out_room (rq_cnt_q != 2'd2),
		.job_pop  (job_pop),
		.win_raddr(win_raddr),
		.win_rdata(win_rdata),
		.res_push (res_push),
		.res      (res_in),
		.busy     (back_busy)
	);

	`GSR_ASSERT_SAME(a_accept, clk, arst_n, push && !full, qstat.jobs_idle, "word taken while busy")
	`GSR_ASSERT_SAME(a_job_room, clk, arst_n, job_push, qstat.job_room || job_pop, "job overflow")
	`GSR_ASSERT_SAME(a_res_room, clk, arst_n, res_push, rq_cnt_q != 2'd2, "result queue overflow")
	`GSR_ASSERT_NEXT(a_res_idle, clk, arst_n, res_push, !back_busy, "back end busy after its result")

endmodule

// ===== hw/rtl/gsr_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module gsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/gsr_front.sv =====
// Front end: accepts sample words, writes the window and queues one job per output channel.
// Depends on gsr_pkg.
module gsr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  gsr_pkg::item_t              item,
	input  gsr_pkg::queue_status_t      qstat,
	output logic                        job_push,
	output gsr_pkg::job_t               job,
	output logic                        win_we,
	output logic [gsr_pkg::SLOT_W-1:0]  win_waddr,
	output logic [31:0]                 win_wdata
);

	gsr_pkg::front_state_t state_q, state_nxt;
	logic [gsr_pkg::POS_W-1:0]  pos_q, nout_q, jcnt_q, plast_q;
	logic [gsr_pkg::SLOT_W-1:0] slot_q, nout_slot_q, jslot_q;
	logic                       accept, row_done;
	logic [gsr_pkg::POS_W:0]    hi_ext;

	assign accept   = push && !full;
	assign row_done = item.row_end || (pos_q == gsr_pkg::POS_W'(gsr_pkg::MAX_ROW - 1));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			gsr_pkg::FR_ACCEPT: begin
				if (accept && row_done) begin
					state_nxt = gsr_pkg::FR_FLUSH;
				end
			end
			gsr_pkg::FR_FLUSH: begin
				if (qstat.job_room && jcnt_q == plast_q) begin
					state_nxt = gsr_pkg::FR_ACCEPT;
				end
			end
			default: state_nxt = gsr_pkg::FR_ACCEPT;
		endcase
	end

	always_comb begin
		full      = 1'b1;
		job_push  = 1'b0;
		job       = '0;
		hi_ext    = '0;
		win_we    = 1'b0;
		win_waddr = slot_q;
		win_wdata = item.sample;
		unique case (state_q)
			gsr_pkg::FR_ACCEPT: begin
				full   = !qstat.jobs_idle;
				win_we = accept;
				if (accept && !row_done && pos_q >= gsr_pkg::POS_W'(gsr_pkg::HALF_WIDTH)) begin
					job_push = 1'b1;
					job.j    = pos_q - gsr_pkg::POS_W'(gsr_pkg::HALF_WIDTH);
					job.hi   = pos_q;
					if (pos_q >= gsr_pkg::POS_W'(2 * gsr_pkg::HALF_WIDTH)) begin
						job.lo      = pos_q - gsr_pkg::POS_W'(2 * gsr_pkg::HALF_WIDTH);
						job.lo_slot = gsr_pkg::slot_inc(slot_q);
					end
				end
			end
			gsr_pkg::FR_FLUSH: begin
				job_push = qstat.job_room;
				job.j    = jcnt_q;
				job.last = (jcnt_q == plast_q);
				hi_ext   = {1'b0, jcnt_q} + (gsr_pkg::POS_W + 1)'(gsr_pkg::HALF_WIDTH);
				job.hi   = (hi_ext > {1'b0, plast_q}) ? plast_q : hi_ext[gsr_pkg::POS_W-1:0];
				if (jcnt_q >= gsr_pkg::POS_W'(gsr_pkg::HALF_WIDTH)) begin
					job.lo      = jcnt_q - gsr_pkg::POS_W'(gsr_pkg::HALF_WIDTH);
					job.lo_slot = gsr_pkg::slot_back(jslot_q,
						gsr_pkg::SLOT_W'(gsr_pkg::HALF_WIDTH));
				end
			end
			default: full = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gsr_pkg::FR_ACCEPT;
			pos_q       <= '0;
			slot_q      <= '0;
			nout_q      <= '0;
			nout_slot_q <= '0;
			jcnt_q      <= '0;
			jslot_q     <= '0;
			plast_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == gsr_pkg::FR_ACCEPT && accept) begin
				if (row_done) begin
					jcnt_q      <= nout_q;
					jslot_q     <= nout_slot_q;
					plast_q     <= pos_q;
					pos_q       <= '0;
					slot_q      <= '0;
					nout_q      <= '0;
					nout_slot_q <= '0;
				end else begin
					if (pos_q >= gsr_pkg::POS_W'(gsr_pkg::HALF_WIDTH)) begin
						nout_q      <= pos_q - gsr_pkg::POS_W'(gsr_pkg::HALF_WIDTH - 1);
						nout_slot_q <= gsr_pkg::slot_back(slot_q,
							gsr_pkg::SLOT_W'(gsr_pkg::HALF_WIDTH - 1));
					end
					pos_q  <= pos_q + gsr_pkg::POS_W'(1);
					slot_q <= gsr_pkg::slot_inc(slot_q);
				end
			end
			if (state_q == gsr_pkg::FR_FLUSH && qstat.job_room) begin
				jcnt_q  <= jcnt_q + gsr_pkg::POS_W'(1);
				jslot_q <= gsr_pkg::slot_inc(jslot_q);
			end
		end
	end

endmodule

// ===== hw/rtl/gsr_back.sv =====
// Back end: runs one job at a time through a pipelined weight and multiply-accumulate path.
// Depends on gsr_pkg; reads the sample window through the RAM port in the top level.
module gsr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [gsr_pkg::INV_W-1:0]   inv_sigma,
	input  logic                        job_valid,
	input  gsr_pkg::job_t               job,
	input  logic                        out_room,
	output logic                        job_pop,
	output logic [gsr_pkg::SLOT_W-1:0]  win_raddr,
	input  logic [31:0]                 win_rdata,
	output logic                        res_push,
	output gsr_pkg::result_t            res,
	output logic                        busy
);

	gsr_pkg::back_state_t state_q, state_nxt;
	logic [gsr_pkg::POS_W-1:0]  k_q, j_q, hi_q;
	logic [gsr_pkg::SLOT_W-1:0] rslot_q;
	logic                       last_q, issue, tap_last;
	logic [gsr_pkg::POS_W-1:0]  tap_dist;

	logic                       v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic                       t_s1, t_s2, t_s3, t_s4, t_s5, t_s6, t_s7, t_s8, t_s9, t_s10;
	logic                       n_s2, n_s3, n_s4, n_s5, n_s6, n_s7, n_s8, n_s9, n_s10;
	logic [gsr_pkg::DIST_W-1:0] d_s1;
	logic [31:0]                m_s2, m_s3, m_s4, m_s5, m_s6, m_s7, m_s8;
	logic [gsr_pkg::ZQ_W-1:0]   zq_s2;
	logic [gsr_pkg::ZSQ_W-1:0]  zsq_s3;
	logic                       ok_s4, ok_s5;
	logic [gsr_pkg::IDXQ_W+gsr_pkg::RECIP_W-1:0] q_s4;
	logic [gsr_pkg::EXP_W-1:0]  rom_s5;
	logic [50:0]                w1_prod;
	logic [34:0]                w1_s6;
	logic [46:0]                pl_s7;
	logic [45:0]                ph_s7;
	logic [64:0]                wsum;
	logic [32:0]                wt_s8;
	logic [48:0]                ml_s9;
	logic [47:0]                mh_s9;
	logic [65:0]                tsum;
	logic [33:0]                term_s10;
	logic [30:0]                acc_q;
	logic signed [35:0]         acc_sum;
	logic [30:0]                acc_nxt;

	assign tap_last = (k_q == hi_q);
	assign tap_dist = (k_q > j_q) ? k_q - j_q : j_q - k_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			gsr_pkg::BK_IDLE: begin
				if (job_valid && out_room) begin
					state_nxt = gsr_pkg::BK_RUN;
				end
			end
			gsr_pkg::BK_RUN: begin
				if (tap_last) begin
					state_nxt = gsr_pkg::BK_DRAIN;
				end
			end
			gsr_pkg::BK_DRAIN: begin
				if (v_s10 && t_s10) begin
					state_nxt = gsr_pkg::BK_IDLE;
				end
			end
			default: state_nxt = gsr_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		job_pop = 1'b0;
		issue   = 1'b0;
		busy    = 1'b1;
		unique case (state_q)
			gsr_pkg::BK_IDLE: begin
				busy    = 1'b0;
				job_pop = job_valid && out_room;
			end
			gsr_pkg::BK_RUN:   issue = 1'b1;
			gsr_pkg::BK_DRAIN: issue = 1'b0;
			default:           busy  = 1'b1;
		endcase
	end

	assign win_raddr = rslot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gsr_pkg::BK_IDLE;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			acc_q <= '0;
		end else begin
			state_q <= state_nxt;
			v_s1  <= issue;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			if (job_pop) begin
				acc_q <= '0;
			end else if (v_s10) begin
				acc_q <= acc_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			k_q     <= job.lo;
			j_q     <= job.j;
			hi_q    <= job.hi;
			rslot_q <= job.lo_slot;
			last_q  <= job.last;
		end else if (issue) begin
			k_q     <= k_q + gsr_pkg::POS_W'(1);
			rslot_q <= gsr_pkg::slot_inc(rslot_q);
		end
		t_s1  <= tap_last;
		d_s1  <= tap_dist[gsr_pkg::DIST_W-1:0];

		t_s2  <= t_s1;
		zq_s2 <= gsr_pkg::ZQ_W'(d_s1 * inv_sigma);
		n_s2  <= win_rdata[31];
		m_s2  <= win_rdata[31] ? (~win_rdata + 32'd1) : win_rdata;

		t_s3   <= t_s2;
		n_s3   <= n_s2;
		m_s3   <= m_s2;
		zsq_s3 <= zq_s2 * zq_s2;

		t_s4  <= t_s3;
		n_s4  <= n_s3;
		m_s4  <= m_s3;
		ok_s4 <= (zsq_s3 < gsr_pkg::ZSQ_LIMIT);
		q_s4  <= zsq_s3[gsr_pkg::IDX_SHIFT +: gsr_pkg::IDXQ_W] * gsr_pkg::RECIP_5;

		t_s5   <= t_s4;
		n_s5   <= n_s4;
		m_s5   <= m_s4;
		ok_s5  <= ok_s4;
		rom_s5 <= gsr_pkg::EXP_ROM[q_s4[16 +: gsr_pkg::ROM_AW]];

		t_s6  <= t_s5;
		n_s6  <= n_s5;
		m_s6  <= m_s5;
		w1_s6 <= ok_s5 ? w1_prod[50:16] : '0;

		t_s7  <= t_s6;
		n_s7  <= n_s6;
		m_s7  <= m_s6;
		pl_s7 <= w1_s6[17:0] * gsr_pkg::INV_SQRT_2PI;
		ph_s7 <= w1_s6[34:18] * gsr_pkg::INV_SQRT_2PI;

		t_s8  <= t_s7;
		n_s8  <= n_s7;
		m_s8  <= m_s7;
		wt_s8 <= wsum[62:30];

		t_s9  <= t_s8;
		n_s9  <= n_s8;
		ml_s9 <= m_s8 * wt_s8[16:0];
		mh_s9 <= m_s8 * wt_s8[32:17];

		t_s10    <= t_s9;
		n_s10    <= n_s9;
		term_s10 <= tsum[63:30];
	end

	assign w1_prod = 51'(rom_s5 * inv_sigma) + 51'd32768;
	assign wsum    = (65'(ph_s7) << 18) + 65'(pl_s7) + 65'(gsr_pkg::Q30_HALF);
	assign tsum    = (66'(mh_s9) << 17) + 66'(ml_s9) + 66'(gsr_pkg::Q30_HALF);

	always_comb begin
		if (n_s10) begin
			acc_sum = $signed({5'b0, acc_q}) - $signed({2'b0, term_s10});
		end else begin
			acc_sum = $signed({5'b0, acc_q}) + $signed({2'b0, term_s10});
		end
		if (acc_sum < 0) begin
			acc_nxt = '0;
		end else if (acc_sum > 36'sd2147483647) begin
			acc_nxt = '1;
		end else begin
			acc_nxt = acc_sum[30:0];
		end
	end

	assign res_push     = v_s10 && t_s10;
	assign res.smoothed = acc_nxt;
	assign res.row_last = last_q;

endmodule
